/* rtl/fed_pkg.sv */
`default_nettype none

package fed_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int CH_W       = 3;
  localparam int FRAMES_W   = 14;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN    = 2'd2;

  localparam logic [CH_W-1:0]     CHANNEL_COUNT_RST = 3'd1;
  localparam logic [FRAMES_W-1:0] DELAY_FRAMES_RST  = 14'd9600;
  localparam logic [GAIN_W-1:0]   DECAY_GAIN_RST    = 16'd32768;

  localparam int DELAY_DEPTH_DEF = 65536;
  localparam int CHANNEL_LIMIT   = 6;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

endpackage

`default_nettype wire

/* rtl/fed_ram.sv */
`default_nettype none

module fed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/fed_seq.sv */
`default_nettype none

module fed_seq #(
  parameter int DELAY_DEPTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic                           last,
  input  wire logic [fed_pkg::CH_W-1:0]       channel_count,
  input  wire logic [fed_pkg::FRAMES_W-1:0]   delay_frames,
  output logic [$clog2(DELAY_DEPTH)-1:0]      rd_addr,
  output logic [$clog2(DELAY_DEPTH)-1:0]      wr_addr,
  output logic                                gate,
  output logic                                dist_one
);

  import fed_pkg::*;

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int DPW   = FRAMES_W + CH_W;
  localparam int CMP_W = (AW + 1 > DPW) ? AW + 1 : DPW;
  localparam logic [AW:0]      DEPTH_V   = (AW + 1)'(DELAY_DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DELAY_DEPTH);
  localparam logic [AW-1:0]    WP_LAST   = AW'(DELAY_DEPTH - 1);

  logic [AW-1:0] wp;
  logic [AW:0]   fill;

  logic [CH_W-1:0]     ch_eff;
  logic [FRAMES_W-1:0] fr_eff;
  logic [DPW-1:0]      dist_raw;
  logic [CMP_W-1:0]    dist_ext;
  logic [AW:0]         span;
  logic [AW:0]         wp_ext;
  logic [AW:0]         rd_wide;

  always_comb begin
    if (channel_count == '0) begin
      ch_eff = CH_W'(1);
    end else if (32'(channel_count) > CHANNEL_LIMIT) begin
      ch_eff = CH_W'(CHANNEL_LIMIT);
    end else begin
      ch_eff = channel_count;
    end
    fr_eff   = (delay_frames == '0) ? FRAMES_W'(1) : delay_frames;
    dist_raw = DPW'(fr_eff) * DPW'(ch_eff);
    dist_ext = CMP_W'(dist_raw);
    // A distance longer than the store reads the oldest entry.
    if (dist_ext > DEPTH_CMP) begin
      span = DEPTH_V;
    end else begin
      span = dist_ext[AW:0];
    end
    wp_ext = {1'b0, wp};
    if (wp_ext >= span) begin
      rd_wide = wp_ext - span;
    end else begin
      rd_wide = wp_ext + DEPTH_V - span;
    end
  end

  assign rd_addr  = rd_wide[AW-1:0];
  assign wr_addr  = wp;
  assign gate     = (fill >= span);
  assign dist_one = (span == (AW + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (accept) begin
      wp <= (wp == WP_LAST) ? '0 : wp + AW'(1);
      if (last) begin
        fill <= '0;
      end else if (fill < DEPTH_V) begin
        fill <= fill + (AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/feedback_echo_delay_core.sv */
`default_nettype none
// A sample passes through stage 1, stage 2 and the output register before it appears.
// Throughput: one sample per cycle unless the output stalls; when the delay
// distance is one sample, each waits on the multiply-add recurrence via the store.
// Reset clears the write pointer, the fill count and the pipeline, and returns the
// registers to their defaults; the delay store itself is not cleared.

module feedback_echo_delay_core #(
  parameter int DELAY_DEPTH = fed_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [fed_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [fed_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [fed_pkg::SAMPLE_W-1:0]  sample_in,
  input  wire logic                                 last_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [fed_pkg::SAMPLE_W-1:0]       sample_out,
  output logic                                      clipped,
  output logic                                      end_of_stream
);

  import fed_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  logic [CH_W-1:0]     channel_count;
  logic [FRAMES_W-1:0] delay_frames;
  logic [GAIN_W-1:0]   decay_gain;

  logic          accept;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          gate;
  logic          dist_one;

  logic [SAMPLE_W-1:0] ram_q;

  // Stage 1: read data arrives.
  logic                       s1_v;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic                       s1_last;
  logic                       s1_gate;
  logic                       s1_hit;
  logic signed [SAMPLE_W-1:0] s1_fwd;
  logic [AW-1:0]              s1_waddr;

  // Stage 2: product registered, sum and write back.
  logic                       s2_v;
  logic signed [SAMPLE_W-1:0] s2_x;
  logic                       s2_last;
  logic                       s2_gate;
  logic signed [PROD_W-1:0]   s2_prod;
  logic [AW-1:0]              s2_waddr;

  logic                       out_load;
  logic                       s1_adv;
  logic signed [SAMPLE_W-1:0] past;
  logic signed [PROD_W:0]     mult_full;
  logic signed [SAMPLE_W-1:0] echo;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W-1:0] y;
  logic                       clip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      delay_frames  <= DELAY_FRAMES_RST;
      decay_gain    <= DECAY_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CH_W-1:0];
        REG_DELAY_FRAMES:  delay_frames  <= cfg_data[FRAMES_W-1:0];
        REG_DECAY_GAIN:    decay_gain    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load = s2_v && (!out_valid || out_ready);
  assign s1_adv   = s1_v && (!s2_v || out_load);

  // With a one-sample distance the next sample needs the result still in the
  // pipeline, so it waits until that result is being written.
  always_comb begin
    in_ready = !s1_v || s1_adv;
    if (dist_one && (s1_v || (s2_v && !out_load))) begin
      in_ready = 1'b0;
    end
  end

  assign accept = in_valid && in_ready;

  fed_seq #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .last          (last_sample),
    .channel_count (channel_count),
    .delay_frames  (delay_frames),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .gate          (gate),
    .dist_one      (dist_one)
  );

  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (out_load),
    .waddr (s2_waddr),
    .wdata (y),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // A read issued in the same cycle as a write to that entry takes the new value.
  assign past      = s1_hit ? s1_fwd : $signed(ram_q);
  assign mult_full = past * $signed({1'b0, decay_gain});

  assign echo = s2_prod[PROD_W-1:GAIN_W];
  assign sum  = {s2_x[SAMPLE_W-1], s2_x} + {echo[SAMPLE_W-1], echo};

  always_comb begin
    y    = s2_x;
    clip = 1'b0;
    if (s2_gate) begin
      if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
        y    = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        clip = 1'b1;
      end else begin
        y = sum[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        s2_v <= 1'b1;
      end else if (out_load) begin
        s2_v <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= sample_in;
      s1_last  <= last_sample;
      s1_gate  <= gate;
      s1_hit   <= out_load && (s2_waddr == rd_addr);
      s1_fwd   <= y;
      s1_waddr <= wr_addr;
    end
    if (s1_adv) begin
      s2_x     <= s1_x;
      s2_last  <= s1_last;
      s2_gate  <= s1_gate;
      s2_prod  <= mult_full[PROD_W-1:0];
      s2_waddr <= s1_waddr;
    end
    if (out_load) begin
      sample_out    <= y;
      clipped       <= clip;
      end_of_stream <= s2_last;
    end
  end

endmodule

`default_nettype wire
